### hw/rtl/assert_macros.svh
// assertion macros for the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BMP565_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define BMP565_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/bmp565_pkg.sv
// shared types and constants of the bmp to rgb565 decoder
// no dependencies
`default_nettype none

package bmp565_pkg;

  // result kinds on the output channel
  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_BADSIG = 2'd2,
    KIND_UNSUP  = 2'd3
  } kind_e;

  // configuration register indexes
  localparam logic CFG_ORIGIN_X = 1'b0;
  localparam logic CFG_ORIGIN_Y = 1'b1;

  // header constants
  localparam logic [7:0]  SIG_B       = 8'h42;
  localparam logic [7:0]  SIG_M       = 8'h4D;
  localparam logic [15:0] BPP_24      = 16'd24;
  localparam logic [15:0] PLANES_ONE  = 16'd1;
  localparam logic [5:0]  HDR_LAST    = 6'd33;
  localparam logic [31:0] PIX_OFF_MIN = 32'd34;

endpackage

`default_nettype wire

### hw/rtl/bmp565_if.sv
// valid/ready channel interfaces for file bytes in and decoded results out
// no dependencies
`default_nettype none

interface bmp565_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       starts_file;

  modport source (output valid, output file_byte, output starts_file, input ready);
  modport sink   (input valid, input file_byte, input starts_file, output ready);
endinterface

interface bmp565_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic        final_res;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [15:0] color;

  modport source (output valid, output result_kind, output final_res, output pixel_x,
                  output pixel_y, output color, input ready);
  modport sink   (input valid, input result_kind, input final_res, input pixel_x,
                  input pixel_y, input color, output ready);
endinterface

`default_nettype wire

### hw/rtl/bmp24_stream_to_rgb565_pixels_core.sv
// bmp 24-bit byte stream to rgb565 pixel decoder, top level
// depends on bmp565_pkg and the channel interfaces in bmp565_if
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-------------------------------------------
//   in_i     | in  | valid/ready   | file_byte, starts_file
//   out_o    | out | valid/ready   | result_kind, final_res, pixel_x/y, color
//   cfg      | in  | cfg_we_i only | cfg_idx_i, cfg_data_i (origin x / y)
//
// a byte transfer lands in the input register; the parser decodes it and
// loads the result register once that register is free or drained
// one byte per cycle sustained while the sink takes results; the input
// register waits only when the result register holds an untaken result
// async active-low reset clears the parser to the header phase at byte 0
// and the origin registers to zero; no clearing pass
`default_nettype none

module bmp24_stream_to_rgb565_pixels_core
  import bmp565_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  bmp565_in_if.sink        in_i,
  bmp565_out_if.source     out_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SKIP   = 2'd1,
    PH_PIXELS = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  // drop byte b into lane k of a little-endian word
  function automatic logic [31:0] put_lane32(input logic [31:0] w, input logic [1:0] k,
                                             input logic [7:0] b);
    logic [31:0] r;
    r = w;
    r[{k, 3'b000} +: 8] = b;
    return r;
  endfunction

  // configuration
  logic [15:0] origin_x_q, origin_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORIGIN_X: origin_x_q <= cfg_data_i;
        CFG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_start_q;
  logic       out_valid_q;
  logic       s1_adv, s1_fire, in_xfer;

  // the decode stage moves whenever the result register is free or drained
  assign s1_adv   = !out_valid_q || out_o.ready;
  assign s1_fire  = s1_valid_q && s1_adv;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q  <= in_i.file_byte;
      s1_start_q <= in_i.starts_file;
    end
  end

  // parser state
  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic        sig_ok_q, sig_ok_d;
  logic [31:0] pix_off_q, pix_off_d;
  logic [31:0] width_q, width_d;
  logic [31:0] height_q, height_d;
  logic [15:0] planes_q, planes_d;
  logic [15:0] bpp_q, bpp_d;
  logic [31:0] comp_q, comp_d;
  logic [31:0] col_q, col_d;
  logic [31:0] row_q, row_d;
  logic [1:0]  chan_q, chan_d;
  logic [1:0]  pad_q, pad_d;
  logic [7:0]  blue_q, blue_d;
  logic [7:0]  green_q, green_d;

  // result
  logic        res_valid;
  kind_e       res_kind;
  logic        res_final;
  logic [15:0] res_x, res_y, res_color;

  kind_e       kind_q;
  logic        final_q;
  logic [15:0] x_q, y_q, color_q;

  // working values
  logic [7:0]  b;
  logic [5:0]  pos6;
  logic        do_pix;
  logic [31:0] col_inc, row_inc;

  assign b    = s1_byte_q;
  // position of the byte being decoded, zero when it carries the start mark
  assign pos6 = s1_start_q ? 6'd0 : pos_q[5:0];

  always_comb begin
    // start mark clears the parser before the byte is looked at
    if (s1_start_q) begin
      phase_d  = PH_HEADER;
      pos_d    = '0;
      sig_ok_d = 1'b0;
      pix_off_d = '0;
      width_d  = '0;
      height_d = '0;
      planes_d = '0;
      bpp_d    = '0;
      comp_d   = '0;
      col_d    = '0;
      row_d    = '0;
      chan_d   = '0;
      pad_d    = '0;
      blue_d   = '0;
      green_d  = '0;
    end else begin
      phase_d  = phase_q;
      pos_d    = pos_q;
      sig_ok_d = sig_ok_q;
      pix_off_d = pix_off_q;
      width_d  = width_q;
      height_d = height_q;
      planes_d = planes_q;
      bpp_d    = bpp_q;
      comp_d   = comp_q;
      col_d    = col_q;
      row_d    = row_q;
      chan_d   = chan_q;
      pad_d    = pad_q;
      blue_d   = blue_q;
      green_d  = green_q;
    end

    res_valid = 1'b0;
    res_kind  = KIND_PIXEL;
    res_final = 1'b0;
    res_x     = '0;
    res_y     = '0;
    res_color = '0;
    do_pix    = 1'b0;
    col_inc   = col_q + 32'd1;
    row_inc   = row_q + 32'd1;

    case (phase_d)
      PH_HEADER: begin
        // header never runs past byte 33, so the low bits name the position
        if (pos6 == 6'd0) begin
          sig_ok_d = (b == SIG_B);
        end else if (pos6 == 6'd1) begin
          sig_ok_d = sig_ok_q && (b == SIG_M);
        end else if (pos6 >= 6'd10 && pos6 <= 6'd13) begin
          pix_off_d = put_lane32(pix_off_q, 2'(pos6 - 6'd10), b);
        end else if (pos6 >= 6'd18 && pos6 <= 6'd21) begin
          width_d = put_lane32(width_q, 2'(pos6 - 6'd18), b);
        end else if (pos6 >= 6'd22 && pos6 <= 6'd25) begin
          height_d = put_lane32(height_q, 2'(pos6 - 6'd22), b);
        end else if (pos6 == 6'd26 || pos6 == 6'd27) begin
          planes_d = pos6[0] ? {b, planes_q[7:0]} : {planes_q[15:8], b};
        end else if (pos6 == 6'd28 || pos6 == 6'd29) begin
          bpp_d = pos6[0] ? {b, bpp_q[7:0]} : {bpp_q[15:8], b};
        end else if (pos6 >= 6'd30 && pos6 <= 6'd33) begin
          comp_d = put_lane32(comp_q, 2'(pos6 - 6'd30), b);
        end

        if (pos6 == HDR_LAST) begin
          // last header byte: compression top byte is this very byte
          if (!sig_ok_q) begin
            phase_d   = PH_DONE;
            res_valid = 1'b1;
            res_kind  = KIND_BADSIG;
            res_final = 1'b1;
          end else if (planes_q != PLANES_ONE || bpp_q != BPP_24 ||
                       comp_q[23:0] != 24'd0 || b != 8'd0 ||
                       pix_off_q < PIX_OFF_MIN) begin
            phase_d   = PH_DONE;
            res_valid = 1'b1;
            res_kind  = KIND_UNSUP;
            res_final = 1'b1;
          end else if (width_q == 32'd0 || height_q == 32'd0) begin
            phase_d   = PH_DONE;
            res_valid = 1'b1;
            res_kind  = KIND_EMPTY;
            res_final = 1'b1;
          end else begin
            phase_d = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (pos_d >= pix_off_q) begin
          phase_d = PH_PIXELS;
          do_pix  = 1'b1;
        end
      end
      PH_PIXELS: begin
        do_pix = 1'b1;
      end
      default: ;
    endcase

    if (do_pix) begin
      if (pad_q != 2'd0) begin
        pad_d = pad_q - 2'd1;
      end else if (chan_q == 2'd0) begin
        blue_d = b;
        chan_d = 2'd1;
      end else if (chan_q == 2'd1) begin
        green_d = b;
        chan_d  = 2'd2;
      end else begin
        // red byte completes the triple
        chan_d    = 2'd0;
        res_valid = 1'b1;
        res_kind  = KIND_PIXEL;
        res_x     = origin_x_q + col_q[15:0];
        res_y     = origin_y_q + height_q[15:0] - 16'd1 - row_q[15:0];
        res_color = {b[7:3], green_q[7:2], blue_q[7:3]};
        if (col_inc == width_q) begin
          col_d = '0;
          row_d = row_inc;
          pad_d = width_q[1:0];
          if (row_inc == height_q) begin
            res_final = 1'b1;
            phase_d   = PH_DONE;
          end
        end else begin
          col_d = col_inc;
        end
      end
    end

    // position counts every byte until the file is done
    if (phase_q != PH_DONE || s1_start_q) begin
      pos_d = pos_d + 32'd1;
    end
  end

  // parser state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      pos_q       <= '0;
      sig_ok_q    <= 1'b0;
      pix_off_q   <= '0;
      width_q     <= '0;
      height_q    <= '0;
      planes_q    <= '0;
      bpp_q       <= '0;
      comp_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      chan_q      <= '0;
      pad_q       <= '0;
      blue_q      <= '0;
      green_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_fire) begin
        phase_q     <= phase_d;
        pos_q       <= pos_d;
        sig_ok_q    <= sig_ok_d;
        pix_off_q   <= pix_off_d;
        width_q     <= width_d;
        height_q    <= height_d;
        planes_q    <= planes_d;
        bpp_q       <= bpp_d;
        comp_q      <= comp_d;
        col_q       <= col_d;
        row_q       <= row_d;
        chan_q      <= chan_d;
        pad_q       <= pad_d;
        blue_q      <= blue_d;
        green_q     <= green_d;
        out_valid_q <= res_valid;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (s1_fire && res_valid) begin
      kind_q  <= res_kind;
      final_q <= res_final;
      x_q     <= res_x;
      y_q     <= res_y;
      color_q <= res_color;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = kind_q;
  assign out_o.final_res   = final_q;
  assign out_o.pixel_x     = x_q;
  assign out_o.pixel_y     = y_q;
  assign out_o.color       = color_q;

endmodule

`default_nettype wire

### hw/rtl/bmp565_checker.sv
// port-level assertions for the bmp to rgb565 decoder, bound to its top level
// depends on bmp565_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bmp565_checker
  import bmp565_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  out_kind_i,
  input wire logic        out_final_i,
  input wire logic [15:0] out_x_i,
  input wire logic [15:0] out_y_i,
  input wire logic [15:0] out_color_i
);

  // a stalled result stays put
  `BMP565_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable({out_kind_i, out_final_i, out_x_i, out_y_i, out_color_i}))

  // every non-pixel result ends its file
  `BMP565_ASSERT_IMP(a_status_final, clk_i, rst_ni, out_valid_i && out_kind_i != KIND_PIXEL, out_final_i)

  // non-pixel results carry no coordinates or color
  `BMP565_ASSERT_IMP(a_status_zero, clk_i, rst_ni, out_valid_i && out_kind_i != KIND_PIXEL, out_x_i == 16'd0 && out_y_i == 16'd0 && out_color_i == 16'd0)

  // with the result register empty the input side never stalls
  `BMP565_ASSERT_IMP(a_in_free, clk_i, rst_ni, !out_valid_i, in_ready_i)

  // a fresh result follows a byte transfer through the input register and the result register
  `BMP565_ASSERT_IMP(a_out_cause, clk_i, rst_ni, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2))

endmodule

bind bmp24_stream_to_rgb565_pixels_core bmp565_checker u_bmp565_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.result_kind),
  .out_final_i (out_o.final_res),
  .out_x_i     (out_o.pixel_x),
  .out_y_i     (out_o.pixel_y),
  .out_color_i (out_o.color)
);

`default_nettype wire

### verif/tb_bmp24_stream_to_rgb565_pixels_core.sv
`timescale 1ns / 100ps
// self-checking testbench for the bmp 24-bit to rgb565 decoder core
// depends on bmp565_pkg, the channel interfaces in bmp565_if and the core itself

module tb_bmp24_stream_to_rgb565_pixels_core;
  import bmp565_pkg::*;

  localparam int RANDOM_BYTES     = 100;
  localparam int SINK_HOLD_CYCLES = 500;
  localparam int N_DIRECTED       = 17;

  // one decoder output as it should appear on the result channel
  typedef struct packed {
    kind_e       kind;
    logic        fin;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] color;
  } result_t;

  // one file to stream: header fields, how much of it to send, and for the
  // error rows the result kind that the bench expects at the last header byte
  typedef struct packed {
    logic [15:0] ox;
    logic [15:0] oy;
    logic [7:0]  sig0;
    logic [7:0]  sig1;
    logic [31:0] offset;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] planes;
    logic [15:0] bpp;
    logic [31:0] comp;
    logic        start;     // start mark on the first byte
    int          hdr_len;   // header bytes sent, 34 for a whole header
    int          body_len;  // bytes after the header, -1 for the whole image
    int          trail;     // junk bytes after the body
    logic        typed;     // result at the last header byte is given below
    kind_e       exp_kind;
  } file_t;

  typedef enum logic [1:0] {ST_HEADER, ST_SKIP, ST_PIXELS, ST_DONE} stage_e;

  logic clk = 1'b0;
  logic rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [15:0] cfg_data;

  bmp565_in_if  in_bus ();
  bmp565_out_if out_bus ();

  bmp24_stream_to_rgb565_pixels_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // decoder state mirror, advanced once per accepted byte transfer
  // ---------------------------------------------------------------------------
  stage_e      stage;
  logic [31:0] pos_q;
  logic        sig_ok;
  logic [31:0] offset_q;
  logic [31:0] width_q;
  logic [31:0] height_q;
  logic [15:0] planes_q;
  logic [15:0] bpp_q;
  logic [31:0] comp_q;
  logic [31:0] col_q;
  logic [31:0] row_q;
  logic [1:0]  chan_q;
  logic [1:0]  pad_q;
  logic [7:0]  blue_q;
  logic [7:0]  green_q;
  logic [15:0] org_x;
  logic [15:0] org_y;

  result_t decoded_q[$];   // decoder outputs still to come, oldest first
  int      mismatch_cnt = 0;
  int      parsed_bytes = 0; // bytes that reached the parser outside the done phase
  bit      calm = 1'b0;      // no idle cycles on either side while set
  bit      hold_req = 1'b0;  // asks the result side for one long hold-off

  task automatic restart_parser();
    stage    = ST_HEADER;
    pos_q    = '0;
    sig_ok   = 1'b0;
    offset_q = '0;
    width_q  = '0;
    height_q = '0;
    planes_q = '0;
    bpp_q    = '0;
    comp_q   = '0;
    col_q    = '0;
    row_q    = '0;
    chan_q   = '0;
    pad_q    = '0;
    blue_q   = '0;
    green_q  = '0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic s, output bit hit,
                             output result_t r);
    logic [31:0] p;
    logic [31:0] ysum;
    stage_e      was;
    hit = 1'b0;
    r   = '0;
    if (s) restart_parser();
    if (stage != ST_DONE) parsed_bytes++;
    p   = pos_q;
    was = stage;
    if (stage != ST_DONE) pos_q = pos_q + 32'd1;

    if (was == ST_HEADER) begin
      // little-endian header fields gathered lane by lane
      if (p == 32'd0) sig_ok = (b == SIG_B);
      else if (p == 32'd1) sig_ok = sig_ok && (b == SIG_M);
      else if (p >= 32'd10 && p <= 32'd13) offset_q[(p - 32'd10) * 8 +: 8] = b;
      else if (p >= 32'd18 && p <= 32'd21) width_q[(p - 32'd18) * 8 +: 8] = b;
      else if (p >= 32'd22 && p <= 32'd25) height_q[(p - 32'd22) * 8 +: 8] = b;
      else if (p >= 32'd26 && p <= 32'd27) planes_q[(p - 32'd26) * 8 +: 8] = b;
      else if (p >= 32'd28 && p <= 32'd29) bpp_q[(p - 32'd28) * 8 +: 8] = b;
      else if (p >= 32'd30 && p <= 32'd33) comp_q[(p - 32'd30) * 8 +: 8] = b;

      // verdict on the last header byte: signature first, then format, then size
      if (p == 32'(HDR_LAST)) begin
        if (!sig_ok) begin
          stage = ST_DONE;
          hit   = 1'b1;
          r.kind = KIND_BADSIG;
          r.fin  = 1'b1;
        end else if (planes_q != PLANES_ONE || bpp_q != BPP_24 || comp_q != 32'd0 ||
                     offset_q < PIX_OFF_MIN) begin
          stage = ST_DONE;
          hit   = 1'b1;
          r.kind = KIND_UNSUP;
          r.fin  = 1'b1;
        end else if (width_q == 32'd0 || height_q == 32'd0) begin
          stage = ST_DONE;
          hit   = 1'b1;
          r.kind = KIND_EMPTY;
          r.fin  = 1'b1;
        end else begin
          stage = ST_SKIP;
        end
      end
    end else if (was == ST_SKIP && p >= offset_q) begin
      stage = ST_PIXELS;
    end

    if (stage == ST_PIXELS) begin
      if (pad_q != 2'd0) begin
        pad_q = pad_q - 2'd1;
      end else if (chan_q == 2'd0) begin
        blue_q = b;
        chan_q = 2'd1;
      end else if (chan_q == 2'd1) begin
        green_q = b;
        chan_q  = 2'd2;
      end else begin
        chan_q  = 2'd0;
        hit     = 1'b1;
        r.kind  = KIND_PIXEL;
        r.x     = org_x + col_q[15:0];
        // rows are stored bottom-up
        ysum    = {16'd0, org_y} + height_q - 32'd1 - row_q;
        r.y     = ysum[15:0];
        r.color = {b[7:3], green_q[7:2], blue_q[7:3]};
        col_q   = col_q + 32'd1;
        if (col_q == width_q) begin
          col_q = '0;
          row_q = row_q + 32'd1;
          pad_q = width_q[1:0];
          if (row_q == height_q) begin
            r.fin = 1'b1;
            stage = ST_DONE;
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // byte side: random gap, then hold valid until the transfer happens
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic s, output bit hit,
                           output result_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.file_byte   <= b;
    in_bus.starts_file <= s;
    do @(posedge clk); while (!in_bus.ready);
    decode_byte(b, s, hit, r);
  endtask

  task automatic send_file(input file_t f);
    int      body;
    int      n;
    int      i;
    logic [7:0] b;
    bit      hit;
    result_t r;
    result_t fixed_res;
    body = f.body_len;
    if (body < 0) begin
      body = ((f.offset > 32'd34) ? int'(f.offset) - 34 : 0) +
             (3 * int'(f.width) + int'(f.width[1:0])) * int'(f.height);
    end
    n = f.hdr_len + body + f.trail;
    fixed_res = '{f.exp_kind, 1'b1, 16'd0, 16'd0, 16'd0};
    for (i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i < f.hdr_len) begin
        if (i == 0) b = f.sig0;
        else if (i == 1) b = f.sig1;
        else if (i >= 10 && i <= 13) b = f.offset[(i - 10) * 8 +: 8];
        else if (i >= 18 && i <= 21) b = f.width[(i - 18) * 8 +: 8];
        else if (i >= 22 && i <= 25) b = f.height[(i - 22) * 8 +: 8];
        else if (i >= 26 && i <= 27) b = f.planes[(i - 26) * 8 +: 8];
        else if (i >= 28 && i <= 29) b = f.bpp[(i - 28) * 8 +: 8];
        else if (i >= 30 && i <= 33) b = f.comp[(i - 30) * 8 +: 8];
      end
      send_byte(b, (i == 0) ? f.start : 1'b0, hit, r);
      if (f.typed && i == int'(HDR_LAST)) decoded_q.push_back(fixed_res);
      else if (hit) decoded_q.push_back(r);
    end
  endtask

  // stop offering bytes and let every pending result drain out
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // origin writes happen only with the decoder drained
  task automatic set_origin(input logic [15:0] nx, input logic [15:0] ny);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_ORIGIN_X;
    cfg_data <= nx;
    @(posedge clk);
    cfg_idx  <= CFG_ORIGIN_Y;
    cfg_data <= ny;
    @(posedge clk);
    cfg_we   <= 1'b0;
    org_x = nx;
    org_y = ny;
  endtask

  function automatic logic [15:0] pick_origin();
    case ($urandom_range(0, 2))
      0: pick_origin = 16'h0000;
      1: pick_origin = 16'hFFFF;
      default: pick_origin = 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls, one long hold-off on request, field checks
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      $display("%0t: %s expected %h got %h", $time, what, want, got);
    end
  endtask

  initial begin : result_sink
    result_t want;
    int      gap;
    out_bus.ready = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        // long hold-off so the core backs up and stalls byte transfers
        hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
      end
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      // a hold-off request ends the wait even without a result
      do @(posedge clk); while (!out_bus.valid && !hold_req);
      if (out_bus.valid) begin
        if (decoded_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: result with none pending, kind %0d fin %0d x %h y %h color %h",
                   $time, out_bus.result_kind, out_bus.final_res, out_bus.pixel_x,
                   out_bus.pixel_y, out_bus.color);
        end else begin
          want = decoded_q.pop_front();
          compare_field("result_kind", 16'(want.kind), 16'(out_bus.result_kind));
          compare_field("final_res", 16'(want.fin), 16'(out_bus.final_res));
          compare_field("pixel_x", want.x, out_bus.pixel_x);
          compare_field("pixel_y", want.y, out_bus.pixel_y);
          compare_field("color", want.color, out_bus.color);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: directed file table, then random files until enough bytes parsed
  // ---------------------------------------------------------------------------
  initial begin : file_source
    file_t directed_tab [N_DIRECTED];
    file_t f;
    int    base;
    int    k;

    // every input known from time zero
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.file_byte   = 8'h00;
    in_bus.starts_file = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_ORIGIN_X;
    cfg_data           = 16'h0000;
    org_x = 16'h0000;
    org_y = 16'h0000;
    restart_parser();

    // ox, oy, sig0, sig1, offset, width, height, planes, bpp, comp,
    // start, hdr_len, body_len, trail, typed, exp_kind
    // first file after reset carries no start mark, trailing bytes ignored
    directed_tab[0]  = '{16'h0, 16'h0, SIG_B, SIG_M, 32'd34, 32'd2, 32'd2, PLANES_ONE,
                         BPP_24, 32'd0, 1'b0, 34, -1, 2, 1'b0, KIND_PIXEL};
    // broken first signature byte
    directed_tab[1]  = '{16'h0, 16'h0, 8'h41, SIG_M, 32'd34, 32'd2, 32'd2, PLANES_ONE,
                         BPP_24, 32'd0, 1'b1, 34, 0, 3, 1'b1, KIND_BADSIG};
    // broken second signature byte wins over a bad plane count
    directed_tab[2]  = '{16'h0, 16'h0, SIG_B, 8'h4C, 32'd34, 32'd2, 32'd2, 16'd0,
                         BPP_24, 32'd0, 1'b1, 34, 0, 2, 1'b1, KIND_BADSIG};
    // two planes
    directed_tab[3]  = '{16'h0, 16'h0, SIG_B, SIG_M, 32'd34, 32'd2, 32'd2, 16'd2,
                         BPP_24, 32'd0, 1'b1, 34, 0, 1, 1'b1, KIND_UNSUP};
    // bits per pixel with the top bit set
    directed_tab[4]  = '{16'h0, 16'h0, SIG_B, SIG_M, 32'd34, 32'd2, 32'd2, PLANES_ONE,
                         16'h8018, 32'd0, 1'b1, 34, 0, 0, 1'b1, KIND_UNSUP};
    // compressed
    directed_tab[5]  = '{16'h0, 16'h0, SIG_B, SIG_M, 32'd34, 32'd2, 32'd2, PLANES_ONE,
                         BPP_24, 32'h8000_0000, 1'b1, 34, 0, 0, 1'b1, KIND_UNSUP};
    // pixel offset inside the header
    directed_tab[6]  = '{16'h0, 16'h0, SIG_B, SIG_M, 32'd33, 32'd2, 32'd2, PLANES_ONE,
                         BPP_24, 32'd0, 1'b1, 34, 0, 2, 1'b1, KIND_UNSUP};
    // zero width, then zero height
    directed_tab[7]  = '{16'h0, 16'h0, SIG_B, SIG_M, 32'd34, 32'd0, 32'd5, PLANES_ONE,
                         BPP_24, 32'd0, 1'b1, 34, 0, 4, 1'b1, KIND_EMPTY};
    directed_tab[8]  = '{16'h0, 16'h0, SIG_B, SIG_M, 32'd34, 32'd3, 32'd0, PLANES_ONE,
                         BPP_24, 32'd0, 1'b1, 34, 0, 1, 1'b1, KIND_EMPTY};
    // top origins so the row coordinate wraps, skipped bytes before the pixels
    directed_tab[9]  = '{16'hFFFF, 16'hFFFF, SIG_B, SIG_M, 32'd40, 32'd1, 32'd2,
                         PLANES_ONE, BPP_24, 32'd0, 1'b1, 34, -1, 0, 1'b0, KIND_PIXEL};
    // three-wide rows carry three padding bytes
    directed_tab[10] = '{16'h1234, 16'h0FF0, SIG_B, SIG_M, 32'd54, 32'd3, 32'd2,
                         PLANES_ONE, BPP_24, 32'd0, 1'b1, 34, -1, 3, 1'b0, KIND_PIXEL};
    directed_tab[11] = '{16'h1234, 16'h0FF0, SIG_B, SIG_M, 32'd34, 32'd5, 32'd1,
                         PLANES_ONE, BPP_24, 32'd0, 1'b1, 34, -1, 2, 1'b0, KIND_PIXEL};
    // largest size, cut off mid-row by the next start mark
    directed_tab[12] = '{16'h1234, 16'h0FF0, SIG_B, SIG_M, 32'd34, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, PLANES_ONE, BPP_24, 32'd0, 1'b1, 34, 12, 0,
                         1'b0, KIND_PIXEL};
    // huge height makes the row coordinate wrap
    directed_tab[13] = '{16'h0000, 16'hFFFF, SIG_B, SIG_M, 32'd34, 32'd2, 32'h8000_0000,
                         PLANES_ONE, BPP_24, 32'd0, 1'b1, 34, 8, 0, 1'b0, KIND_PIXEL};
    // header cut short by a new start mark
    directed_tab[14] = '{16'h0000, 16'h0000, SIG_B, SIG_M, 32'd34, 32'd2, 32'd2,
                         PLANES_ONE, BPP_24, 32'd0, 1'b1, 20, 0, 0, 1'b0, KIND_PIXEL};
    // four-wide rows, no padding
    directed_tab[15] = '{16'h0000, 16'h0000, SIG_B, SIG_M, 32'd34, 32'd4, 32'd2,
                         PLANES_ONE, BPP_24, 32'd0, 1'b1, 34, -1, 1, 1'b0, KIND_PIXEL};
    // offset far beyond the data, every byte skipped
    directed_tab[16] = '{16'h0000, 16'h0000, SIG_B, SIG_M, 32'hFFFF_FFFF, 32'd2, 32'd2,
                         PLANES_ONE, BPP_24, 32'd0, 1'b1, 34, 10, 0, 1'b0, KIND_PIXEL};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < N_DIRECTED; k++) begin
      if (directed_tab[k].ox != org_x || directed_tab[k].oy != org_y) begin
        set_origin(directed_tab[k].ox, directed_tab[k].oy);
      end
      // the hold-off outlasts the header, so the first pixels of this file back up
      if (k == 15) hold_req = 1'b1;
      send_file(directed_tab[k]);
    end

    // random files: mostly well-formed small images with random content,
    // the rest corrupted headers, cut-short files and noise
    base = parsed_bytes;
    while (parsed_bytes - base < RANDOM_BYTES) begin
      if ($urandom_range(0, 4) == 0) set_origin(pick_origin(), pick_origin());
      calm = ($urandom_range(0, 3) == 0);

      f = '{org_x, org_y, SIG_B, SIG_M, 32'd34 + 32'($urandom_range(0, 6)),
            32'($urandom_range(1, 5)), 32'($urandom_range(1, 3)), PLANES_ONE, BPP_24,
            32'd0, 1'b1, 34, -1, $urandom_range(0, 3), 1'b0, KIND_PIXEL};
      case ($urandom_range(0, 9))
        0: f.body_len = $urandom_range(0, 10);
        7: begin
          case ($urandom_range(0, 7))
            0: f.sig0   = 8'($urandom_range(0, 255));
            1: f.sig1   = 8'($urandom_range(0, 255));
            2: f.planes = 16'($urandom_range(0, 65535));
            3: f.bpp    = 16'($urandom_range(0, 65535));
            4: f.comp   = $urandom;
            5: f.offset = $urandom_range(0, 33);
            6: f.width  = 32'd0;
            default: f.height = 32'd0;
          endcase
        end
        8: f.hdr_len = $urandom_range(1, 33);
        9: begin
          f.sig0     = 8'($urandom_range(0, 255));
          f.sig1     = 8'($urandom_range(0, 255));
          f.offset   = $urandom;
          f.width    = $urandom;
          f.height   = $urandom;
          f.planes   = 16'($urandom_range(0, 65535));
          f.bpp      = 16'($urandom_range(0, 65535));
          f.comp     = $urandom;
          f.start    = 1'($urandom_range(0, 1));
          f.body_len = $urandom_range(0, 12);
          f.trail    = 0;
        end
        default: ;
      endcase
      send_file(f);
    end
    calm = 1'b0;

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : run_limit
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### bmp24_stream_to_rgb565_pixels_core.f
+incdir+hw/rtl
hw/rtl/bmp565_pkg.sv
hw/rtl/bmp565_if.sv
hw/rtl/bmp24_stream_to_rgb565_pixels_core.sv
hw/rtl/bmp565_checker.sv
verif/tb_bmp24_stream_to_rgb565_pixels_core.sv
